// File: src/sll_pkg.sv
`timescale 1ns / 1ps

package sll_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NONODE = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Field widths of the stream payload
  localparam int POS_BITS    = 4;
  localparam int IN_VAL_BITS = 32;
  localparam int SLOT_BITS   = 4;
  localparam int ST_BITS     = 2;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // latch a new transaction, reset the cursor
    logic       adv_head;  // cursor <= head link
    logic       adv_ram;   // cursor <= link read data
    logic       scan_inc;  // next candidate slot
    logic       clr_step;  // one entry of the post-reset in-use clear
    logic       ins_w1;    // write new node: link, in-use, value
    logic       ins_w2;    // link predecessor to new node
    logic       del_w1;    // bypass victim, free it
    logic       del_w2;    // null the victim link
    logic       out_load;  // load result register
    logic [1:0] out_status;
  } sll_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic range_bad;
    logic ptr_null;
    logic ptr_head;
    logic walk_end;
    logic slot_free;
    logic scan_last;
    logic op;
    logic out_busy;
  } sll_sts_t;

endpackage

// File: src/sll_ram.sv
`timescale 1ns / 1ps

module sll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/sll_datapath.sv
`timescale 1ns / 1ps

module sll_datapath #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sll_pkg::sll_cmd_t                   cmd,
  output sll_pkg::sll_sts_t                   sts,
  input  logic                                in_op,
  input  logic [sll_pkg::POS_BITS-1:0]        in_pos,
  input  logic signed [sll_pkg::IN_VAL_BITS-1:0] in_value,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [sll_pkg::ST_BITS-1:0]         out_status,
  output logic [sll_pkg::SLOT_BITS-1:0]       out_slot
);

  localparam int ADDR_BITS = $clog2(CAPACITY);
  localparam int LINK_BITS = $clog2(CAPACITY + 1);
  localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(CAPACITY);
  localparam logic [ADDR_BITS-1:0] LAST_SLOT = ADDR_BITS'(CAPACITY - 1);

  // Transaction registers
  logic                            op_r;
  logic [sll_pkg::POS_BITS-1:0]    pos_r;
  logic [VALUE_BITS-1:0]           value_r;
  logic [LINK_BITS-1:0]            ptr_r;
  logic [sll_pkg::POS_BITS:0]      cnt_r;
  logic [ADDR_BITS-1:0]            pred_r;
  logic [ADDR_BITS-1:0]            victim_r;
  logic [ADDR_BITS-1:0]            scan_r;
  logic [LINK_BITS-1:0]            head_r;
  logic                            out_valid_r;
  logic [sll_pkg::ST_BITS-1:0]     out_status_r;
  logic [sll_pkg::SLOT_BITS-1:0]   out_slot_r;

  logic [2*sll_pkg::IN_VAL_BITS+sll_pkg::IN_VAL_BITS-1:0] value_ext;
  logic [sll_pkg::POS_BITS:0]      pos_ext;
  logic [sll_pkg::POS_BITS:0]      pred_cnt;
  logic [sll_pkg::POS_BITS:0]      end_cnt;
  logic                            pred_head;
  logic [LINK_BITS-1:0]            adv_link;
  logic [ADDR_BITS-1:0]            slot_sel;
  logic [ADDR_BITS+sll_pkg::SLOT_BITS-1:0] slot_ext;

  // Memory ports
  logic                  lk_we;
  logic [ADDR_BITS-1:0]  lk_wa;
  logic [LINK_BITS-1:0]  lk_wd;
  logic [LINK_BITS-1:0]  lk_rd;
  logic                  iu_we;
  logic [ADDR_BITS-1:0]  iu_wa;
  logic [0:0]            iu_wd;
  logic [0:0]            iu_rd;
  logic                  vs_we;
  logic [ADDR_BITS-1:0]  vs_wa;
  logic [VALUE_BITS-1:0] vs_wd;
  logic [VALUE_BITS-1:0] vs_rd;

  assign value_ext = {{(2*sll_pkg::IN_VAL_BITS){in_value[sll_pkg::IN_VAL_BITS-1]}}, in_value};
  assign pos_ext   = {1'b0, pos_r};
  assign pred_cnt  = pos_ext - 1'b1;
  assign end_cnt   = pos_ext + {{sll_pkg::POS_BITS{1'b0}}, op_r};
  assign pred_head = (pred_r == '0);
  assign adv_link  = cmd.adv_head ? head_r : lk_rd;

  // Status back to the controller
  always_comb begin
    sts.range_bad = (pos_r == '0) || (int'(pos_r) > CAPACITY - 1);
    sts.ptr_null  = (ptr_r == NULL_LINK);
    sts.ptr_head  = (ptr_r == '0);
    sts.walk_end  = (cnt_r == end_cnt);
    sts.slot_free = (iu_rd == 1'b0);
    sts.scan_last = (scan_r == LAST_SLOT);
    sts.op        = op_r;
    sts.out_busy  = out_valid_r && !out_tready;
  end

  // Link store write port
  always_comb begin
    lk_we = 1'b0;
    lk_wa = scan_r;
    lk_wd = ptr_r;
    if (cmd.ins_w1) begin
      lk_we = 1'b1;
    end
    if (cmd.ins_w2 && !pred_head) begin
      lk_we = 1'b1;
      lk_wa = pred_r;
      lk_wd = LINK_BITS'(scan_r);
    end
    if (cmd.del_w1 && !pred_head) begin
      lk_we = 1'b1;
      lk_wa = pred_r;
      lk_wd = ptr_r;
    end
    if (cmd.del_w2) begin
      lk_we = 1'b1;
      lk_wa = victim_r;
      lk_wd = NULL_LINK;
    end
  end

  // In-use and value store write ports
  always_comb begin
    iu_we = cmd.clr_step || cmd.ins_w1 || cmd.del_w1;
    iu_wa = cmd.del_w1 ? victim_r : scan_r;
    iu_wd = cmd.clr_step ? (scan_r == '0) : cmd.ins_w1;
    vs_we = cmd.ins_w1 || cmd.del_w1;
    vs_wa = cmd.del_w1 ? victim_r : scan_r;
    vs_wd = cmd.del_w1 ? '0 : value_r;
  end

  sll_ram #(.WIDTH(LINK_BITS), .DEPTH(CAPACITY)) u_link_ram (
    .clk     (clk),
    .wr_en   (lk_we),
    .wr_addr (lk_wa),
    .wr_data (lk_wd),
    .rd_addr (ptr_r[ADDR_BITS-1:0]),
    .rd_data (lk_rd)
  );

  sll_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_used_ram (
    .clk     (clk),
    .wr_en   (iu_we),
    .wr_addr (iu_wa),
    .wr_data (iu_wd),
    .rd_addr (scan_r),
    .rd_data (iu_rd)
  );

  sll_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
    .clk     (clk),
    .wr_en   (vs_we),
    .wr_addr (vs_wa),
    .wr_data (vs_wd),
    .rd_addr (victim_r),
    .rd_data (vs_rd)
  );

  // Result slot: new node on insert, freed node on delete, zero on a failure
  always_comb begin
    slot_sel = '0;
    if (cmd.out_status == sll_pkg::ST_OK) begin
      slot_sel = (op_r == sll_pkg::OP_DELETE) ? victim_r : scan_r;
    end
    slot_ext = {{sll_pkg::SLOT_BITS{1'b0}}, slot_sel};
  end

  // Control registers: head link, clear/scan counter, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NULL_LINK;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_r <= ADDR_BITS'(1);
      end else if (cmd.clr_step || cmd.scan_inc) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.ins_w2 && pred_head) begin
        head_r <= LINK_BITS'(scan_r);
      end else if (cmd.del_w1 && pred_head) begin
        head_r <= ptr_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload, walk cursor and result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      pos_r   <= in_pos;
      value_r <= value_ext[VALUE_BITS-1:0];
      ptr_r   <= '0;
      cnt_r   <= '0;
    end else if (cmd.adv_head || cmd.adv_ram) begin
      if (cnt_r == pred_cnt) begin
        pred_r <= ptr_r[ADDR_BITS-1:0];
      end
      if (cnt_r == pos_ext) begin
        victim_r <= ptr_r[ADDR_BITS-1:0];
      end
      ptr_r <= adv_link;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_slot_r   <= slot_ext[sll_pkg::SLOT_BITS-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

// File: src/sll_ctrl.sv
`timescale 1ns / 1ps

module sll_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sll_pkg::sll_sts_t sts,
  output sll_pkg::sll_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_WALK_WAIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_INS_W1,
    S_INS_W2,
    S_DEL_W1,
    S_DEL_W2,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] res_r, res_nxt;
  logic       rdy_r, rdy_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.scan_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && rdy_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.range_bad) begin
          res_nxt   = sll_pkg::ST_RANGE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        priority if (sts.walk_end) begin
          state_nxt = (sts.op == sll_pkg::OP_DELETE) ? S_DEL_W1 : S_SCAN_RD;
        end else if (sts.ptr_null) begin
          res_nxt   = sll_pkg::ST_NONODE;
          state_nxt = S_OUT;
        end else if (sts.ptr_head) begin
          cmd.adv_head = 1'b1;
        end else begin
          state_nxt = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        cmd.adv_ram = 1'b1;
        state_nxt   = S_WALK;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        priority if (sts.slot_free) begin
          state_nxt = S_INS_W1;
        end else if (sts.scan_last) begin
          res_nxt   = sll_pkg::ST_FULL;
          state_nxt = S_OUT;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_INS_W1: begin
        cmd.ins_w1 = 1'b1;
        state_nxt  = S_INS_W2;
      end
      S_INS_W2: begin
        cmd.ins_w2 = 1'b1;
        res_nxt    = sll_pkg::ST_OK;
        state_nxt  = S_OUT;
      end
      S_DEL_W1: begin
        cmd.del_w1 = 1'b1;
        state_nxt  = S_DEL_W2;
      end
      S_DEL_W2: begin
        cmd.del_w2 = 1'b1;
        res_nxt    = sll_pkg::ST_OK;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        cmd.out_status = res_r;
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    rdy_nxt = (state_nxt == S_IDLE);
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      res_r   <= sll_pkg::ST_OK;
      rdy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

  assign in_tready = rdy_r;

endmodule

// File: src/static_linked_list_engine_unit.sv
`timescale 1ns / 1ps
// After acceptance the block checks the position and walks the links from the head (one more
// link on delete); an insert then probes slots in a lowest-free-slot scan, writes the new
// node and links its predecessor, and the result loads into the result register. A bad
// position goes from the check straight to the result. A held result stalls the block until it is taken.
// Only one transaction is in flight; the next is taken in the cycle after the result loads.
// Reset: synchronous, active low; then a clear of the in-use store during which in_tready
// stays low. The head starts empty.

module static_linked_list_engine_unit #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] position, [35:4] value, [39:36] zero
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [5:2] slot, [7:6] zero
);

  sll_pkg::sll_cmd_t cmd;
  sll_pkg::sll_sts_t sts;

  logic [sll_pkg::ST_BITS-1:0]   res_status;
  logic [sll_pkg::SLOT_BITS-1:0] res_slot;

  sll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sll_datapath #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_pos     (in_tdata[3:0]),
    .in_value   (in_tdata[35:4]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_status (res_status),
    .out_slot   (res_slot)
  );

  assign out_tdata = {2'b00, res_slot, res_status};

  // A failed transaction never reports a slot
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != sll_pkg::ST_OK) |-> out_tdata[5:2] == '0)
    else $error("slot nonzero on failed transaction");

  // Only one transaction in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // Clear pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during clear pass");

  // A result is loaded only when the block has finished and is not taking input
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a transaction in progress");

endmodule
